>>> design/lekr_pkg.sv
// Shared types and constants for the line editor with key repeat.
package lekr_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int NOW_W          = 32;
    localparam int DELAY_W        = 16;
    localparam int CAP_W          = 11;
    localparam int LEN_W          = 10;
    localparam int CHAR_W         = 8;
    localparam int SCAN_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [DELAY_W-1:0] DELAY_RST  = 16'd400;
    localparam logic [DELAY_W-1:0] PERIOD_RST = 16'd35;
    localparam logic [CAP_W-1:0]   CAP_RST    = 11'd512;
    localparam logic [CAP_W-1:0]   CAP_MAX    = 11'd1024;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_FIRST = 8'd32;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'd126;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_PRESS   = 2'd1,
        REQ_RELEASE = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_DONE   = 3'd3,
        ACT_EOF    = 3'd4,
        ACT_INTR   = 3'd5
    } t_action;

    localparam logic [1:0] LTR_D = 2'd1;
    localparam logic [1:0] LTR_C = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NOW_W-1:0]  now_ms;
        logic [CHAR_W-1:0] key_char;
        logic              ctrl_down;
        logic [1:0]        ctrl_letter;
        logic              enter_flag;
        logic              backspace_flag;
        logic [SCAN_W-1:0] scan_code;
        logic              key_source;
    } t_item;

    typedef struct packed {
        t_action           action;
        logic [CHAR_W-1:0] out_char;
        logic [LEN_W-1:0]  position;
    } t_res;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] period;
        logic [CAP_W-1:0]   cap;
    } t_cfg;

endpackage

>>> design/lekr_step.sv
// Next-state and result logic for one line editor item.
module lekr_step import lekr_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  t_item                i_item,
    input  t_cfg                 i_cfg,
    input  logic [LEN_W-1:0]     i_len,
    input  logic                 i_hold_act,
    input  logic [SCAN_W-1:0]    i_hold_scan,
    input  logic                 i_hold_usb,
    input  logic [CHAR_W-1:0]    i_hold_char,
    input  logic [TIME_BITS-1:0] i_hold_start,
    input  logic [TIME_BITS-1:0] i_last_rep,
    output logic [LEN_W-1:0]     o_len,
    output logic                 o_hold_act,
    output logic [SCAN_W-1:0]    o_hold_scan,
    output logic                 o_hold_usb,
    output logic [CHAR_W-1:0]    o_hold_char,
    output logic [TIME_BITS-1:0] o_hold_start,
    output logic [TIME_BITS-1:0] o_last_rep,
    output t_res                 o_res
);

    logic [TIME_BITS-1:0] now_t, delay_t, period_t, lrt_eff;
    logic [CAP_W-1:0]     eff_cap, len_p1;
    logic                 room, rep_fire, is_press_bs, is_print;
    logic                 do_apply;
    logic [CHAR_W-1:0]    chr;

    assign now_t    = TIME_BITS'(i_item.now_ms);
    assign delay_t  = TIME_BITS'(i_cfg.delay);
    assign period_t = TIME_BITS'(i_cfg.period);

    // zero capacity behaves as one, anything above the buffer as the buffer
    always_comb begin
        if (i_cfg.cap == '0) begin
            eff_cap = CAP_W'(1);
        end else if (i_cfg.cap > CAP_MAX) begin
            eff_cap = CAP_MAX;
        end else begin
            eff_cap = i_cfg.cap;
        end
    end

    assign len_p1 = {1'b0, i_len} + CAP_W'(1);
    assign room   = len_p1 < eff_cap;

    // first repeat is measured from press time plus delay
    assign lrt_eff  = (i_last_rep == '0) ? (i_hold_start + delay_t) : i_last_rep;
    assign rep_fire = (now_t - lrt_eff) >= period_t;

    assign is_press_bs = i_item.backspace_flag || (i_item.key_char == CH_BS);
    assign is_print    = (i_item.key_char >= CH_FIRST) && (i_item.key_char <= CH_LAST);

    always_comb begin
        o_len        = i_len;
        o_hold_act   = i_hold_act;
        o_hold_scan  = i_hold_scan;
        o_hold_usb   = i_hold_usb;
        o_hold_char  = i_hold_char;
        o_hold_start = i_hold_start;
        o_last_rep   = i_last_rep;
        o_res        = '{action: ACT_NONE, out_char: '0, position: '0};
        do_apply     = 1'b0;
        chr          = i_hold_char;

        case (t_req'(i_item.req_type))
            REQ_TICK: begin
                if (i_hold_act && (now_t != '0) && ((now_t - i_hold_start) >= delay_t)) begin
                    o_last_rep = lrt_eff;
                    if (rep_fire) begin
                        o_last_rep = now_t;
                        do_apply   = 1'b1;
                    end
                end
            end
            REQ_PRESS: begin
                if (i_item.ctrl_down) begin
                    if (i_item.ctrl_letter == LTR_D) begin
                        if (i_len == '0) begin
                            o_res.action = ACT_EOF;
                        end else begin
                            o_res.action   = ACT_DONE;
                            o_res.position = i_len;
                        end
                        o_len      = '0;
                        o_hold_act = 1'b0;
                    end else if (i_item.ctrl_letter == LTR_C) begin
                        o_res.action = ACT_INTR;
                        o_len        = '0;
                        o_hold_act   = 1'b0;
                    end
                end else if (i_item.enter_flag || (i_item.key_char == CH_LF) ||
                             (i_item.key_char == CH_CR)) begin
                    o_res.action   = ACT_DONE;
                    o_res.position = i_len;
                    o_len          = '0;
                    o_hold_act     = 1'b0;
                end else if (is_press_bs || is_print) begin
                    chr          = is_press_bs ? CH_BS : i_item.key_char;
                    do_apply     = 1'b1;
                    o_hold_act   = 1'b1;
                    o_hold_scan  = i_item.scan_code;
                    o_hold_usb   = i_item.key_source;
                    o_hold_char  = chr;
                    o_hold_start = now_t;
                    o_last_rep   = '0;
                end
            end
            REQ_RELEASE: begin
                if (i_hold_act && (i_hold_scan == i_item.scan_code) &&
                    (i_hold_usb == i_item.key_source)) begin
                    o_hold_act = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // shared edit of the line by one character
        if (do_apply) begin
            if (chr == CH_BS) begin
                if (i_len != '0) begin
                    o_len          = i_len - LEN_W'(1);
                    o_res.action   = ACT_ERASE;
                    o_res.position = i_len - LEN_W'(1);
                end
            end else if ((chr >= CH_FIRST) && (chr <= CH_LAST) && room) begin
                o_len          = len_p1[LEN_W-1:0];
                o_res.action   = ACT_APPEND;
                o_res.out_char = chr;
                o_res.position = i_len;
            end
        end
    end

endmodule

>>> design/lekr_obuf.sv
// Result register stage with downstream handshake.
module lekr_obuf import lekr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_res i_res,
    input  logic i_take,
    output logic o_free,
    output logic o_valid,
    output t_res o_res
);

    logic r_vld;
    t_res r_res;

    assign o_free  = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> design/line_editor_with_key_repeat.sv
// Top level of the line editor with typematic key repeat.
//
// Builds one text line from key events and ms ticks and returns exactly one
// result beat per input beat: an action (none, append, erase, line done, end
// of file, interrupted), the appended character and a write position. Each
// input beat lands in an input register, is processed by the combinational
// editing logic against the line and hold state, and its result lands in an
// output register. A new beat is taken every cycle while results drain;
// the result is loaded into the output register as its beat leaves the input register. Backpressure on
// the result side stalls the input register and, through it, s_axis_tready.
// Repeat timing uses TIME_BITS-wide wrapping arithmetic on now_ms; a tick
// with now_ms zero never repeats. Configuration writes (index 0 repeat delay,
// 1 repeat period, 2 line capacity) are always accepted and are to be issued
// only while the block is idle; other indexes are ignored.
module line_editor_with_key_repeat import lekr_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] now_ms, [39:32] key_char, [40] ctrl_down, [42:41] ctrl_letter,
    // [43] enter_flag, [44] backspace_flag, [52:45] scan_code, [53] key_source
    input  logic [55:0]           s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] out_char, [17:8] position
    output logic [23:0]           m_axis_tdata,
    // [2:0] action
    output logic [2:0]            m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay  <= DELAY_RST;
            r_cfg.period <= PERIOD_RST;
            r_cfg.cap    <= CAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DELAY:  r_cfg.delay  <= i_cfg_data;
                CFG_PERIOD: r_cfg.period <= i_cfg_data;
                CFG_CAP:    r_cfg.cap    <= i_cfg_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    logic  r_in_vld;
    t_item r_in;
    logic  out_free, adv, s_acc;

    assign adv           = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in.req_type       <= s_axis_tuser;
            r_in.now_ms         <= s_axis_tdata[31:0];
            r_in.key_char       <= s_axis_tdata[39:32];
            r_in.ctrl_down      <= s_axis_tdata[40];
            r_in.ctrl_letter    <= s_axis_tdata[42:41];
            r_in.enter_flag     <= s_axis_tdata[43];
            r_in.backspace_flag <= s_axis_tdata[44];
            r_in.scan_code      <= s_axis_tdata[52:45];
            r_in.key_source     <= s_axis_tdata[53];
        end
    end

    // line and hold state
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_hold_act, n_hold_act;
    logic [SCAN_W-1:0]    r_hold_scan, n_hold_scan;
    logic                 r_hold_usb, n_hold_usb;
    logic [CHAR_W-1:0]    r_hold_char, n_hold_char;
    logic [TIME_BITS-1:0] r_hold_start, n_hold_start;
    logic [TIME_BITS-1:0] r_last_rep, n_last_rep;
    t_res                 step_res, out_res;

    lekr_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .i_len        (r_len),
        .i_hold_act   (r_hold_act),
        .i_hold_scan  (r_hold_scan),
        .i_hold_usb   (r_hold_usb),
        .i_hold_char  (r_hold_char),
        .i_hold_start (r_hold_start),
        .i_last_rep   (r_last_rep),
        .o_len        (n_len),
        .o_hold_act   (n_hold_act),
        .o_hold_scan  (n_hold_scan),
        .o_hold_usb   (n_hold_usb),
        .o_hold_char  (n_hold_char),
        .o_hold_start (n_hold_start),
        .o_last_rep   (n_last_rep),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_hold_act   <= 1'b0;
            r_hold_scan  <= '0;
            r_hold_usb   <= 1'b0;
            r_hold_char  <= '0;
            r_hold_start <= '0;
            r_last_rep   <= '0;
        end else if (adv) begin
            r_len        <= n_len;
            r_hold_act   <= n_hold_act;
            r_hold_scan  <= n_hold_scan;
            r_hold_usb   <= n_hold_usb;
            r_hold_char  <= n_hold_char;
            r_hold_start <= n_hold_start;
            r_last_rep   <= n_last_rep;
        end
    end

    // result register
    lekr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (step_res),
        .i_take  (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.position, out_res.out_char};
    assign m_axis_tuser = out_res.action;

    // input only stalls when a result is waiting and not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // every processed beat produces a result beat
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> m_axis_tvalid)
        else $error("processed beat produced no result");

    // an append grows the line by exactly one
    a_append_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (step_res.action == ACT_APPEND)) |=> (r_len == $past(r_len) + LEN_W'(1)))
        else $error("append did not advance line length");

    // ending a line clears length and hold
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && ((step_res.action == ACT_DONE) || (step_res.action == ACT_EOF) ||
                 (step_res.action == ACT_INTR))) |=> ((r_len == '0) && !r_hold_act))
        else $error("line end left state behind");

endmodule

>>> tb/tb.sv
// Testbench for the line editor: scripted and random key beats checked against a line model.
`timescale 1ns / 100ps

module tb import lekr_pkg::*; ();

    // Request code outside the enum; the block must ignore it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Config index that maps to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Ctrl letter codes that are neither D nor C.
    localparam logic [1:0] LTR_OTHER = 2'd0;
    localparam logic [1:0] LTR_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    line_editor_with_key_repeat dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Line model: registers mirrored from the config writes, plus the
    // line length and the held-key (typematic) state.
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0] cfg_delay  = DELAY_RST;
    logic [DELAY_W-1:0] cfg_period = PERIOD_RST;
    logic [CAP_W-1:0]   cfg_cap    = CAP_RST;

    logic [LEN_W-1:0]  model_len    = '0;
    bit                held         = 1'b0;
    logic [SCAN_W-1:0] held_scan    = '0;
    bit                held_usb     = 1'b0;
    logic [CHAR_W-1:0] held_char    = '0;
    logic [NOW_W-1:0]  held_since   = '0;
    logic [NOW_W-1:0]  last_rep     = '0;  // zero: no repeat yet

    t_res pending_echo[$];   // results still owed by the block
    int   fail_count = 0;
    int   results_seen = 0;

    // Stimulus-side timekeeping and idle control.
    logic [NOW_W-1:0] clock_ms = 32'd1;
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;
    int sink_hold = 0;

    typedef struct {
        t_item key;
        bit    fixed;   // result typed in the script, else from the model
        t_res  want;
    } t_row;
    t_row script[$];

    function automatic t_res res(input t_action a, input logic [CHAR_W-1:0] c,
                                 input logic [LEN_W-1:0] p);
        t_res r;
        r.action   = a;
        r.out_char = c;
        r.position = p;
        return r;
    endfunction

    function automatic t_item mk(input logic [1:0] req, input logic [NOW_W-1:0] now,
                                 input logic [CHAR_W-1:0] kc, input bit ctrl,
                                 input logic [1:0] ltr, input bit ent, input bit bs,
                                 input logic [SCAN_W-1:0] scan, input bit src);
        t_item k;
        k.req_type       = req;
        k.now_ms         = now;
        k.key_char       = kc;
        k.ctrl_down      = ctrl;
        k.ctrl_letter    = ltr;
        k.enter_flag     = ent;
        k.backspace_flag = bs;
        k.scan_code      = scan;
        k.key_source     = src;
        return k;
    endfunction

    // Capacity clamp: zero behaves as one, anything past 1024 as 1024.
    function automatic int room();
        int c;
        c = int'(cfg_cap);
        if (c == 0) c = 1;
        if (c > 1024) c = 1024;
        return c;
    endfunction

    // Apply a backspace or printable character to the line.
    function automatic t_res type_char(input logic [CHAR_W-1:0] c);
        t_res r;
        r = '0;
        if (c == CH_BS) begin
            if (model_len != 0) begin
                model_len  = model_len - LEN_W'(1);
                r.action   = ACT_ERASE;
                r.position = model_len;
            end
        end else if (c >= CH_FIRST && c <= CH_LAST && int'(model_len) + 1 < room()) begin
            r.action   = ACT_APPEND;
            r.out_char = c;
            r.position = model_len;
            model_len  = model_len + LEN_W'(1);
        end
        return r;
    endfunction

    function automatic void grab_key(input t_item k, input logic [CHAR_W-1:0] c);
        held       = 1'b1;
        held_scan  = k.scan_code;
        held_usb   = k.key_source;
        held_char  = c;
        held_since = k.now_ms;
        last_rep   = '0;
    endfunction

    function automatic void close_line();
        model_len = '0;
        held      = 1'b0;
    endfunction

    // One input beat in, exactly one result out.
    function automatic t_res edit_step(input t_item k);
        t_res r;
        r = '0;
        case (k.req_type)
            REQ_TICK: begin
                // Repeat fires one period after the delay has passed, then every period;
                // all time math wraps at 32 bits.
                if (held && k.now_ms != 0 && (k.now_ms - held_since) >= 32'(cfg_delay)) begin
                    if (last_rep == 0) last_rep = held_since + 32'(cfg_delay);
                    if ((k.now_ms - last_rep) >= 32'(cfg_period)) begin
                        last_rep = k.now_ms;
                        r = type_char(held_char);
                    end
                end
            end
            REQ_PRESS: begin
                if (k.ctrl_down) begin
                    if (k.ctrl_letter == LTR_D) begin
                        r.action   = (model_len == 0) ? ACT_EOF : ACT_DONE;
                        r.position = model_len;
                        close_line();
                    end else if (k.ctrl_letter == LTR_C) begin
                        r.action = ACT_INTR;
                        close_line();
                    end
                end else if (k.enter_flag || k.key_char == CH_LF || k.key_char == CH_CR) begin
                    r.action   = ACT_DONE;
                    r.position = model_len;
                    close_line();
                end else if (k.backspace_flag || k.key_char == CH_BS) begin
                    r = type_char(CH_BS);
                    grab_key(k, CH_BS);
                end else if (k.key_char >= CH_FIRST && k.key_char <= CH_LAST) begin
                    r = type_char(k.key_char);
                    grab_key(k, k.key_char);
                end
            end
            REQ_RELEASE: begin
                if (held && held_scan == k.scan_code && held_usb == k.key_source)
                    held = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Random beat. Most are well-formed key traffic around a running ms
    // clock that steps in proportion to the repeat timing, so holds reach
    // their delay and repeat; the rest is noise.
    function automatic t_item gen_key();
        t_item k;
        int    pick;
        int    span;
        k = mk(2'($urandom), $urandom, 8'($urandom), 1'($urandom), 2'($urandom),
               1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
        pick = $urandom_range(0, 99);
        span = (int'(cfg_delay) + int'(cfg_period)) / 3 + 4;
        if (pick >= 97) return k;
        if (pick < 40) begin
            k.req_type = REQ_TICK;
            if ($urandom_range(0, 49) == 0) clock_ms = $urandom;   // jump, may wrap
            else clock_ms = clock_ms + 32'($urandom_range(0, span));
            k.now_ms = ($urandom_range(0, 19) == 0) ? 32'd0 : clock_ms;
            return k;
        end
        k.now_ms         = ($urandom_range(0, 29) == 0) ? 32'd0 : clock_ms;
        k.req_type       = REQ_PRESS;
        k.ctrl_down      = 1'b0;
        k.enter_flag     = 1'b0;
        k.backspace_flag = 1'b0;
        if (pick < 68) begin
            k.key_char = 8'($urandom_range(32, 126));
        end else if (pick < 76) begin
            if ($urandom_range(0, 1)) k.backspace_flag = 1'b1;
            else k.key_char = CH_BS;
        end else if (pick < 86) begin
            k.req_type = REQ_RELEASE;
            if ($urandom_range(0, 3) != 0) begin
                k.scan_code  = held_scan;
                k.key_source = held_usb;
            end
        end else if (pick < 90) begin
            case ($urandom_range(0, 2))
                0: k.enter_flag = 1'b1;
                1: k.key_char = CH_LF;
                default: k.key_char = CH_CR;
            endcase
        end else if (pick < 94) begin
            k.ctrl_down = 1'b1;
        end else begin
            k.key_char = $urandom_range(0, 1) ? 8'($urandom_range(127, 255))
                                              : 8'($urandom_range(14, 31));
            if ($urandom_range(0, 3) == 0) k.req_type = REQ_UNUSED;
        end
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with NBAs at the rising edge; ready
    // signals are read right after the edge, i.e. their pre-edge value.
    // ------------------------------------------------------------------
    task automatic send_key(input t_item k, input bit fixed, input t_res want);
        t_res r;
        int   gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, k.key_source, k.scan_code, k.backspace_flag,
                          k.enter_flag, k.ctrl_letter, k.ctrl_down, k.key_char, k.now_ms};
        s_axis_tuser  <= k.req_type;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = edit_step(k);
        pending_echo.push_back(fixed ? want : r);
        if ($urandom_range(0, 79) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : idle_len();
        // valid stays up for a back-to-back beat; it only drops for a gap
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Leaves i_cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DELAY:  cfg_delay  = val;
            CFG_PERIOD: cfg_period = val;
            CFG_CAP:    cfg_cap    = val[CAP_W-1:0];
            default: ;
        endcase
    endtask

    // Every beat yields a result, so an empty queue, with the input and
    // output registers drained, means the block is idle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_echo.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] d, input logic [CFG_DATA_W-1:0] p,
                             input logic [CFG_DATA_W-1:0] c, input int beats);
        wait_idle();
        write_reg(CFG_DELAY, d);
        write_reg(CFG_PERIOD, p);
        write_reg(CFG_CAP, c);
        i_cfg_valid <= 1'b0;
        repeat (beats) send_key(gen_key(), 1'b0, '0);
    endtask

    task automatic add_row(input t_item k, input bit f, input t_res w);
        t_row row;
        row.key   = k;
        row.fixed = f;
        row.want  = w;
        script.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, compare against oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sink_side
        int stall;
        if ($urandom_range(0, 299) == 0) sink_calm <= !sink_calm;
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end else begin
            stall = sink_calm ? 0 : idle_len();
            m_axis_tready <= (stall == 0);
            sink_hold     <= (stall > 0) ? stall - 1 : 0;
        end
    end

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_echo.size() == 0) begin
                note_fail($sformatf("result beat %0d with nothing expected: act %0d tdata %h",
                                    results_seen, m_axis_tuser, m_axis_tdata));
            end else begin
                want = pending_echo.pop_front();
                if (m_axis_tuser !== want.action || m_axis_tdata[7:0] !== want.out_char ||
                    m_axis_tdata[17:8] !== want.position)
                    note_fail($sformatf(
                        "beat %0d: exp act %0d char %02h pos %0d, got act %0d char %02h pos %0d",
                        results_seen, want.action, want.out_char, want.position,
                        m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[17:8]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_res none_r;
        none_r = res(ACT_NONE, 8'h00, 10'd0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scripted part at reset settings (delay 400, period 35, capacity 512).
        add_row(mk(REQ_TICK, 32'd0, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
                none_r);
        add_row(mk(REQ_PRESS, 32'd1000, 8'h41, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h1C, 1'b0), 1'b1,
                res(ACT_APPEND, 8'h41, 10'd0));
        // top and bottom of the printable range
        add_row(mk(REQ_PRESS, 32'd1001, CH_LAST, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h35, 1'b1),
                1'b1, res(ACT_APPEND, CH_LAST, 10'd1));
        add_row(mk(REQ_PRESS, 32'd1002, CH_FIRST, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h29, 1'b1),
                1'b1, res(ACT_APPEND, CH_FIRST, 10'd2));
        // non-printables just outside the range: ignored, hold kept
        add_row(mk(REQ_PRESS, 32'd1003, 8'd31, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h10, 1'b0), 1'b1,
                none_r);
        add_row(mk(REQ_PRESS, 32'd1003, 8'd127, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h11, 1'b0), 1'b1,
                none_r);
        add_row(mk(REQ_PRESS, 32'd1003, 8'hFF, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'hFF, 1'b1), 1'b1,
                none_r);
        // zero time never repeats; one ms short of the delay does nothing
        add_row(mk(REQ_TICK, 32'd0, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
                none_r);
        add_row(mk(REQ_TICK, 32'd1401, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
                none_r);
        // delay reached, then one period later the space repeats
        add_row(mk(REQ_TICK, 32'd1402, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0,
                none_r);
        add_row(mk(REQ_TICK, 32'd1437, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0,
                none_r);
        // release: wrong scancode, wrong source, then the matching one
        add_row(mk(REQ_RELEASE, 32'd0, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h28, 1'b1), 1'b0,
                none_r);
        add_row(mk(REQ_RELEASE, 32'd0, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h29, 1'b0), 1'b0,
                none_r);
        add_row(mk(REQ_RELEASE, 32'd0, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h29, 1'b1), 1'b0,
                none_r);
        add_row(mk(REQ_TICK, 32'hFFFF_FFFF, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h00, 1'b0),
                1'b0, none_r);
        // backspace by flag and by code
        add_row(mk(REQ_PRESS, 32'd5000, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b1, 8'h66, 1'b0), 1'b0,
                none_r);
        add_row(mk(REQ_PRESS, 32'd5001, CH_BS, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h66, 1'b0), 1'b0,
                none_r);
        // ctrl with other letters, unknown request: no effect
        add_row(mk(REQ_PRESS, 32'd5002, 8'h71, 1'b1, LTR_OTHER, 1'b0, 1'b0, 8'h15, 1'b0), 1'b1,
                none_r);
        add_row(mk(REQ_PRESS, 32'd5002, 8'h64, 1'b1, LTR_SPARE, 1'b0, 1'b0, 8'h23, 1'b0), 1'b1,
                none_r);
        add_row(mk(REQ_UNUSED, 32'd5003, 8'h61, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h1C, 1'b0), 1'b1,
                none_r);
        // enter by flag, by LF and by CR
        add_row(mk(REQ_PRESS, 32'd5004, 8'h00, 1'b0, LTR_OTHER, 1'b1, 1'b0, 8'h5A, 1'b0), 1'b0,
                none_r);
        add_row(mk(REQ_PRESS, 32'd5005, CH_LF, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h5A, 1'b0), 1'b1,
                res(ACT_DONE, 8'h00, 10'd0));
        add_row(mk(REQ_PRESS, 32'd5006, CH_CR, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h5A, 1'b1), 1'b1,
                res(ACT_DONE, 8'h00, 10'd0));
        add_row(mk(REQ_PRESS, 32'd5007, 8'h64, 1'b1, LTR_D, 1'b0, 1'b0, 8'h23, 1'b0), 1'b1,
                res(ACT_EOF, 8'h00, 10'd0));
        // backspace on an empty line at time zero
        add_row(mk(REQ_PRESS, 32'd0, CH_BS, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h66, 1'b0), 1'b1,
                none_r);
        // hold across the 32-bit wrap, then repeat after it
        add_row(mk(REQ_PRESS, 32'hFFFF_FFF0, 8'h78, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h22, 1'b0),
                1'b1, res(ACT_APPEND, 8'h78, 10'd0));
        add_row(mk(REQ_TICK, 32'h0000_01B0, 8'h00, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h00, 1'b0),
                1'b0, none_r);
        add_row(mk(REQ_PRESS, 32'd20, 8'h64, 1'b1, LTR_D, 1'b0, 1'b0, 8'h23, 1'b0), 1'b0,
                none_r);
        add_row(mk(REQ_PRESS, 32'd7, 8'h79, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h35, 1'b1), 1'b1,
                res(ACT_APPEND, 8'h79, 10'd0));
        add_row(mk(REQ_PRESS, 32'd8, 8'h63, 1'b1, LTR_C, 1'b0, 1'b0, 8'h21, 1'b0), 1'b1,
                res(ACT_INTR, 8'h00, 10'd0));

        @(posedge i_clk);
        foreach (script[i]) send_key(script[i].key, script[i].fixed, script[i].want);

        // Random phases over the register extremes.
        run_phase(16'd0, 16'd0, 16'd1024, 80);           // repeat on every tick
        run_phase(16'hFFFF, 16'hFFFF, 16'd1, 80);        // capacity 1: no room
        run_phase(16'd0, 16'hFFFF, 16'd0, 80);           // capacity 0 acts as 1

        // Unmapped index, and capacity written with junk above bit 10 (-> 5).
        wait_idle();
        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_DELAY, 16'd12);
        write_reg(CFG_PERIOD, 16'd5);
        write_reg(CFG_CAP, 16'hF805);
        i_cfg_valid <= 1'b0;
        repeat (80) send_key(gen_key(), 1'b0, '0);

        // Capacity past 1024 clamps: fill the line to the top and beyond.
        run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(1, 60)), 16'd2047, 0);
        repeat (1030)
            send_key(mk(REQ_PRESS, 32'd0, 8'h6D, 1'b0, LTR_OTHER, 1'b0, 1'b0, 8'h3A, 1'b0),
                     1'b0, '0);
        send_key(mk(REQ_PRESS, 32'd0, 8'h00, 1'b0, LTR_OTHER, 1'b1, 1'b0, 8'h5A, 1'b0),
                 1'b0, '0);
        repeat (80) send_key(gen_key(), 1'b0, '0);

        run_phase(DELAY_RST, PERIOD_RST, 16'(CAP_RST), 80);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> line_editor_with_key_repeat.f
design/lekr_pkg.sv
design/lekr_step.sv
design/lekr_obuf.sv
design/line_editor_with_key_repeat.sv
tb/tb.sv
